// ===== rtl/lpd_pkg.sv =====
`default_nettype none

package lpd_pkg;

  localparam int unsigned LEN_LIMIT     = 1024;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned LEN_W         = 11;
  localparam int unsigned HDR_W         = 2 * BYTE_W;
  localparam int unsigned CNT_W         = 32;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = LEN_W;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DELIVER_ENABLE = CFG_IDX_W'(1);

  localparam logic [LEN_W-1:0] MAX_PAYLOAD_RST = LEN_W'(LEN_LIMIT);
  localparam logic [LEN_W-1:0] LEN_LIMIT_VAL   = LEN_W'(LEN_LIMIT);

  typedef enum logic [1:0] {
    PH_LOW  = 2'd0,
    PH_HIGH = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic              last_of_packet;
    logic [LEN_W-1:0]  frame_length;
    logic [CNT_W-1:0]  malformed_count;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/lpd_core.sv =====
`default_nettype none

module lpd_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            take,
  input  wire logic [lpd_pkg::BYTE_W-1:0]      rx_byte,
  input  wire logic                            cfg_we,
  input  wire logic [lpd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lpd_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                                 res_valid,
  output lpd_pkg::res_t                        res
);
  import lpd_pkg::*;

  logic [LEN_W-1:0]  max_payload;
  logic              deliver_enable;

  phase_t            phase, phase_next;
  logic [BYTE_W-1:0] held_low_byte, held_low_byte_next;
  logic [LEN_W-1:0]  frame_len_reg, frame_len_reg_next;
  logic [LEN_W-1:0]  bytes_left, bytes_left_next;
  logic [CNT_W-1:0]  bad_header_count, bad_header_count_next;

  logic [LEN_W-1:0]  limit;
  logic [HDR_W-1:0]  plen;
  logic              bad_len;
  logic              last;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload    <= MAX_PAYLOAD_RST;
      deliver_enable <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_PAYLOAD:    max_payload    <= cfg_data;
        REG_DELIVER_ENABLE: deliver_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // effective limit is the smaller of the register and the build limit
  assign limit   = (max_payload > LEN_LIMIT_VAL) ? LEN_LIMIT_VAL : max_payload;
  assign plen    = {rx_byte, held_low_byte};
  assign bad_len = (plen == '0) || (plen > HDR_W'(limit));
  assign last    = (bytes_left == LEN_W'(1));

  always_comb begin
    phase_next            = phase;
    held_low_byte_next    = held_low_byte;
    frame_len_reg_next    = frame_len_reg;
    bytes_left_next       = bytes_left;
    bad_header_count_next = bad_header_count;
    res_valid             = 1'b0;
    res.payload_byte      = rx_byte;
    res.last_of_packet    = last;
    res.frame_length      = frame_len_reg;
    res.malformed_count   = bad_header_count;
    case (phase)
      PH_BODY: begin
        if (bytes_left != '0) begin
          bytes_left_next = bytes_left - LEN_W'(1);
          if (last) begin
            phase_next = PH_LOW;
          end
          res_valid = take && deliver_enable;
        end else begin
          held_low_byte_next = rx_byte;
          phase_next         = PH_HIGH;
        end
      end
      PH_HIGH: begin
        if (bad_len) begin
          // drop the oldest header byte and resync on the new one
          bad_header_count_next = bad_header_count + CNT_W'(1);
          held_low_byte_next    = rx_byte;
          phase_next            = PH_HIGH;
        end else begin
          frame_len_reg_next = plen[LEN_W-1:0];
          bytes_left_next    = plen[LEN_W-1:0];
          phase_next         = PH_BODY;
        end
      end
      default: begin
        held_low_byte_next = rx_byte;
        phase_next         = PH_HIGH;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_LOW;
      held_low_byte    <= '0;
      frame_len_reg    <= '0;
      bytes_left       <= '0;
      bad_header_count <= '0;
    end else if (take) begin
      phase            <= phase_next;
      held_low_byte    <= held_low_byte_next;
      frame_len_reg    <= frame_len_reg_next;
      bytes_left       <= bytes_left_next;
      bad_header_count <= bad_header_count_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lpd_out.sv =====
`default_nettype none

module lpd_out (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire lpd_pkg::res_t push_res,
  output logic               full,
  output logic               out_valid,
  input  wire logic          out_stall,
  output lpd_pkg::res_t      out_res
);
  import lpd_pkg::*;

  logic skid_valid;
  res_t skid_res;
  logic pop;

  assign pop  = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push && out_valid && !pop) begin
      skid_valid <= 1'b1;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_res <= skid_res;
      end
    end else if (push && out_valid && !pop) begin
      skid_res <= push_res;
    end else if (push) begin
      out_res <= push_res;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/length_prefix_deframer_top.sv =====
// channel  | handshake               | payload
// ---------+-------------------------+-------------------------------------------
// in       | in_valid / in_stall     | rx_byte
// out      | out_valid / out_stall   | payload_byte, last_of_packet, frame_length,
//          |                         | malformed_count
// cfg      | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// one byte per cycle unless in_stall; results are registered in the output stage
// the rate is set by the single-cycle header and length update in the core
// a two-entry output stage (register plus skid) lets the input keep flowing
// in_stall rises only when both output entries hold undelivered beats
// rst is synchronous and restores the default config and the header phase
`default_nettype none

module length_prefix_deframer_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [lpd_pkg::BYTE_W-1:0]      rx_byte,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [lpd_pkg::BYTE_W-1:0]           payload_byte,
  output logic                                 last_of_packet,
  output logic [lpd_pkg::LEN_W-1:0]            frame_length,
  output logic [lpd_pkg::CNT_W-1:0]            malformed_count,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [lpd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lpd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import lpd_pkg::*;

  logic take;
  logic res_valid;
  res_t res;
  res_t out_res;

  assign take      = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  lpd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .rx_byte   (rx_byte),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res_valid (res_valid),
    .res       (res)
  );

  lpd_out u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_res  (res),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign payload_byte    = out_res.payload_byte;
  assign last_of_packet  = out_res.last_of_packet;
  assign frame_length    = out_res.frame_length;
  assign malformed_count = out_res.malformed_count;

`ifndef SYNTHESIS
  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("skid entry held without an output beat");

  a_result_needs_take: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (in_valid && !in_stall))
    else $error("result produced without an accepted byte");

  a_skid_fill_on_input: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(in_valid) && $past(out_valid) && $past(out_stall))
    else $error("skid filled without a pushed beat against a stalled output");
`endif

endmodule

`default_nettype wire
